// ----- sv/fes_pkg.sv -----
// Shared types, constants and codes for the fragmentation event step block.
`timescale 1ns / 1ps
package fes_pkg;

	localparam int MAX_LENGTH_DEF = 256;

	// Field widths
	localparam int COUNT_W  = 29;
	localparam int LEN_W    = 9;
	localparam int ICNT_W   = 21;
	localparam int CUT_W    = 9;
	localparam int PIECE_W  = 8;
	localparam int TOTAL_W  = 29;
	localparam int RAND_W   = 32;

	// Register interface
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;
	localparam logic [1:0] REG_POLYMER_LENGTH = 2'd0;
	localparam logic [1:0] REG_INITIAL_COUNT  = 2'd1;
	localparam logic [1:0] REG_SPLIT_MODE     = 2'd2;

	// Register reset values and limits
	localparam logic [LEN_W-1:0]  POLYMER_LENGTH_RST = 9'd256;
	localparam logic [ICNT_W-1:0] INITIAL_COUNT_RST  = 21'd1000000;
	localparam logic [ICNT_W-1:0] COUNT_LIMIT        = 21'd1048576;
	localparam logic [LEN_W-1:0]  MIN_LENGTH         = 9'd2;

	// Item function codes
	localparam logic FUNC_RESTART = 1'b0;
	localparam logic FUNC_REACT   = 1'b1;

	typedef struct packed {
		logic [LEN_W-1:0]  polymer_length;
		logic [ICNT_W-1:0] initial_count;
		logic              split_mode;
	} cfg_t;

	typedef struct packed {
		logic [CUT_W-1:0]   cut_length;
		logic [PIECE_W-1:0] piece_length;
		logic [TOTAL_W-1:0] total_weight;
		logic               finished;
	} res_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_MUL_ADD,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_MUL_PIECE,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		UPD_SEL,
		UPD_PIECE,
		UPD_REST
	} upd_t;

endpackage

// ----- sv/fes_ram.sv -----
// Simple dual-port synchronous RAM, one write port, one registered read port.
`timescale 1ns / 1ps
module fes_ram #(
	parameter int WIDTH = fes_pkg::COUNT_W,
	parameter int DEPTH = fes_pkg::MAX_LENGTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/fes_seq.sv -----
// Sequencer: histogram sweeps, weight scan, scaling, prefix search and count updates.
`timescale 1ns / 1ps
module fes_seq #(
	parameter int MAX_LENGTH = fes_pkg::MAX_LENGTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        func,
	input  logic [fes_pkg::RAND_W-1:0]  rand_select,
	input  logic [fes_pkg::RAND_W-1:0]  rand_split,
	input  fes_pkg::cfg_t               cfg,
	input  logic                        res_ready,
	output logic                        res_write,
	output fes_pkg::res_t               res
);

	localparam int IDXW = $clog2(MAX_LENGTH);
	localparam int CW   = fes_pkg::COUNT_W;
	localparam int WW   = CW + IDXW;
	localparam int SUMW = CW + 2 * IDXW;
	localparam int CUTW = fes_pkg::CUT_W;
	localparam int PCW  = fes_pkg::PIECE_W;
	localparam int TW   = fes_pkg::TOTAL_W;
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(MAX_LENGTH - 1);

	fes_pkg::state_t state_q, state_d;
	fes_pkg::upd_t   upd_q;
	logic            boot_q;
	logic            func_q;
	logic [fes_pkg::RAND_W-1:0] rsel_q, rspl_q;
	logic [IDXW-1:0] scan_q;

	// scan pipeline
	logic            v_s1, v_s2;
	logic [IDXW-1:0] idx_s1, idx_s2;
	logic [WW-1:0]   weight_s2;
	logic [SUMW-1:0] acc_q, acc_next;

	// scaling and search
	logic [63:0]     prod_q;
	logic [31:0]     part_q;
	logic [63:0]     tot64;
	logic [31:0]     mul_a, mul_b;
	logic [SUMW-1:0] target_q;
	logic [IDXW-1:0] lo_q, hi_q, mid_w;
	logic [IDXW-1:0] piece_idx, rest_idx, upd_addr;

	// memory ports
	logic            c_we, c_re;
	logic [IDXW-1:0] c_waddr, c_raddr;
	logic [CW-1:0]   c_wdata, c_rdata, clr_data;
	logic            p_re;
	logic [SUMW-1:0] p_rdata;

	// restart loading
	logic [31:0]     len_w;
	logic [IDXW-1:0] len_idx;
	logic [fes_pkg::ICNT_W-1:0] cnt_sat;

	logic accept;

	fes_ram #(.WIDTH(CW), .DEPTH(MAX_LENGTH)) u_count_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.re    (c_re),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	fes_ram #(.WIDTH(SUMW), .DEPTH(MAX_LENGTH)) u_prefix_ram (
		.clk   (clk),
		.we    (v_s2),
		.waddr (idx_s2),
		.wdata (acc_next),
		.re    (p_re),
		.raddr (mid_w),
		.rdata (p_rdata)
	);

	assign in_stall = (state_q != fes_pkg::ST_IDLE);
	assign accept   = in_valid && (state_q == fes_pkg::ST_IDLE);

	// saturated length and count for a restart sweep
	always_comb begin
		if (32'(cfg.polymer_length) < 32'(fes_pkg::MIN_LENGTH)) begin
			len_w = 32'(fes_pkg::MIN_LENGTH);
		end else if (32'(cfg.polymer_length) > 32'(MAX_LENGTH)) begin
			len_w = 32'(MAX_LENGTH);
		end else begin
			len_w = 32'(cfg.polymer_length);
		end
		if (cfg.initial_count > fes_pkg::COUNT_LIMIT) begin
			cnt_sat = fes_pkg::COUNT_LIMIT;
		end else begin
			cnt_sat = cfg.initial_count;
		end
	end
	assign len_idx  = IDXW'(len_w - 32'd1);
	assign clr_data = (scan_q == len_idx) ? CW'(cnt_sat) : '0;

	assign acc_next  = acc_q + SUMW'(weight_s2);
	assign tot64     = 64'(acc_q);
	assign mid_w     = IDXW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	assign piece_idx = prod_q[32 +: IDXW];
	assign rest_idx  = lo_q - piece_idx - IDXW'(1);

	always_comb begin
		case (upd_q)
			fes_pkg::UPD_SEL:   upd_addr = lo_q;
			fes_pkg::UPD_PIECE: upd_addr = piece_idx;
			default:            upd_addr = rest_idx;
		endcase
	end

	always_comb begin
		mul_a = (state_q == fes_pkg::ST_MUL_PIECE) ? rspl_q : rsel_q;
		case (state_q)
			fes_pkg::ST_MUL_LO: mul_b = tot64[31:0];
			fes_pkg::ST_MUL_HI: mul_b = tot64[63:32];
			default:            mul_b = 32'(lo_q);
		endcase
	end

	// next state and memory control
	always_comb begin
		state_d   = state_q;
		c_we      = 1'b0;
		c_waddr   = scan_q;
		c_wdata   = '0;
		c_re      = 1'b0;
		c_raddr   = scan_q;
		p_re      = 1'b0;
		res_write = 1'b0;
		case (state_q)
			fes_pkg::ST_CLEAR: begin
				c_we    = 1'b1;
				c_wdata = clr_data;
				if (scan_q == LAST_IDX) begin
					state_d = boot_q ? fes_pkg::ST_IDLE : fes_pkg::ST_DONE;
				end
			end
			fes_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (func == fes_pkg::FUNC_REACT) ? fes_pkg::ST_SCAN
					                                         : fes_pkg::ST_CLEAR;
				end
			end
			fes_pkg::ST_SCAN: begin
				c_re = 1'b1;
				if (scan_q == LAST_IDX) begin
					state_d = fes_pkg::ST_DRAIN;
				end
			end
			fes_pkg::ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = (acc_q == '0) ? fes_pkg::ST_DONE : fes_pkg::ST_MUL_LO;
				end
			end
			fes_pkg::ST_MUL_LO:  state_d = fes_pkg::ST_MUL_HI;
			fes_pkg::ST_MUL_HI:  state_d = fes_pkg::ST_MUL_ADD;
			fes_pkg::ST_MUL_ADD: state_d = fes_pkg::ST_SRCH_RD;
			fes_pkg::ST_SRCH_RD: begin
				if (lo_q == hi_q) begin
					state_d = fes_pkg::ST_MUL_PIECE;
				end else begin
					p_re    = 1'b1;
					state_d = fes_pkg::ST_SRCH_CMP;
				end
			end
			fes_pkg::ST_SRCH_CMP:  state_d = fes_pkg::ST_SRCH_RD;
			fes_pkg::ST_MUL_PIECE: state_d = fes_pkg::ST_UPD_RD;
			fes_pkg::ST_UPD_RD: begin
				c_re    = 1'b1;
				c_raddr = upd_addr;
				state_d = fes_pkg::ST_UPD_WR;
			end
			fes_pkg::ST_UPD_WR: begin
				c_we    = 1'b1;
				c_waddr = upd_addr;
				if (upd_q == fes_pkg::UPD_SEL) begin
					c_wdata = c_rdata - CW'(1);
					state_d = fes_pkg::ST_UPD_RD;
				end else begin
					c_wdata = c_rdata + CW'(1);
					if (upd_q == fes_pkg::UPD_PIECE && cfg.split_mode) begin
						state_d = fes_pkg::ST_UPD_RD;
					end else begin
						state_d = fes_pkg::ST_DONE;
					end
				end
			end
			fes_pkg::ST_DONE: begin
				if (res_ready) begin
					res_write = 1'b1;
					state_d   = fes_pkg::ST_IDLE;
				end
			end
			default: state_d = fes_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fes_pkg::ST_CLEAR;
			boot_q  <= 1'b1;
			scan_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			acc_q   <= '0;
			upd_q   <= fes_pkg::UPD_SEL;
			lo_q    <= '0;
			hi_q    <= '0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == fes_pkg::ST_SCAN);
			v_s2    <= v_s1;
			if (state_q == fes_pkg::ST_CLEAR && scan_q == LAST_IDX) begin
				boot_q <= 1'b0;
			end
			if (accept) begin
				scan_q <= '0;
			end else if ((state_q == fes_pkg::ST_CLEAR || state_q == fes_pkg::ST_SCAN)
			             && scan_q != LAST_IDX) begin
				scan_q <= scan_q + IDXW'(1);
			end
			if (accept) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= acc_next;
			end
			case (state_q)
				fes_pkg::ST_MUL_ADD: begin
					lo_q <= '0;
					hi_q <= LAST_IDX;
				end
				fes_pkg::ST_SRCH_CMP: begin
					if (p_rdata > target_q) begin
						hi_q <= mid_w;
					end else begin
						lo_q <= mid_w + IDXW'(1);
					end
				end
				fes_pkg::ST_MUL_PIECE: upd_q <= fes_pkg::UPD_SEL;
				fes_pkg::ST_UPD_WR: begin
					if (upd_q == fes_pkg::UPD_SEL) begin
						upd_q <= fes_pkg::UPD_PIECE;
					end else begin
						upd_q <= fes_pkg::UPD_REST;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			rsel_q <= rand_select;
			rspl_q <= rand_split;
		end
		idx_s1    <= scan_q;
		idx_s2    <= idx_s1;
		weight_s2 <= WW'(c_rdata) * WW'(idx_s1);
		case (state_q)
			fes_pkg::ST_MUL_LO, fes_pkg::ST_MUL_PIECE: begin
				prod_q <= 64'(mul_a) * 64'(mul_b);
			end
			fes_pkg::ST_MUL_HI: begin
				part_q <= prod_q[63:32];
				prod_q <= 64'(mul_a) * 64'(mul_b);
			end
			fes_pkg::ST_MUL_ADD: begin
				target_q <= SUMW'(64'(part_q) + prod_q);
			end
			default: ;
		endcase
	end

	always_comb begin
		res = '0;
		if (func_q == fes_pkg::FUNC_REACT) begin
			if (acc_q == '0) begin
				res.finished = 1'b1;
			end else begin
				res.cut_length   = CUTW'({1'b0, lo_q} + (IDXW + 1)'(1));
				res.piece_length = PCW'({1'b0, piece_idx} + (IDXW + 1)'(1));
				res.total_weight = TW'(acc_q);
			end
		end
	end

endmodule

// ----- sv/fragmentation_event_step.sv -----
// Top level: register port, result register and histogram sequencer.
// A react item scans the histogram, scales rand_select by the total weight, searches the
// running weight sums and updates the counts (one more update in split mode); with no
// weight left it ends after the scan. A restart reloads the histogram. One item at a time:
// the next can be taken in the cycle after the result is registered. Reset: a sweep loads the
// histogram, no item is accepted meanwhile; register writes are always taken.
`timescale 1ns / 1ps
module fragmentation_event_step #(
	parameter int MAX_LENGTH = fes_pkg::MAX_LENGTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fes_pkg::PADDR_W-1:0]   paddr,
	input  logic [fes_pkg::PDATA_W-1:0]   pwdata,
	output logic [fes_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	// item in
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          func,
	input  logic [fes_pkg::RAND_W-1:0]    rand_select,
	input  logic [fes_pkg::RAND_W-1:0]    rand_split,
	// item out
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [fes_pkg::CUT_W-1:0]     cut_length,
	output logic [fes_pkg::PIECE_W-1:0]   piece_length,
	output logic [fes_pkg::TOTAL_W-1:0]   total_weight,
	output logic                          finished
);

	fes_pkg::cfg_t cfg_q;
	fes_pkg::res_t res, res_q;
	logic          out_valid_q;
	logic          res_ready, res_write;
	logic          wr_en;

	// Registers are byte addressed at 4*index; pready is tied high, so every
	// access completes without wait states.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.polymer_length <= fes_pkg::POLYMER_LENGTH_RST;
			cfg_q.initial_count  <= fes_pkg::INITIAL_COUNT_RST;
			cfg_q.split_mode     <= 1'b0;
		end else if (wr_en) begin
			case (paddr[3:2])
				fes_pkg::REG_POLYMER_LENGTH: cfg_q.polymer_length <= pwdata[fes_pkg::LEN_W-1:0];
				fes_pkg::REG_INITIAL_COUNT:  cfg_q.initial_count  <= pwdata[fes_pkg::ICNT_W-1:0];
				fes_pkg::REG_SPLIT_MODE:     cfg_q.split_mode     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			fes_pkg::REG_POLYMER_LENGTH: prdata = fes_pkg::PDATA_W'(cfg_q.polymer_length);
			fes_pkg::REG_INITIAL_COUNT:  prdata = fes_pkg::PDATA_W'(cfg_q.initial_count);
			fes_pkg::REG_SPLIT_MODE:     prdata = fes_pkg::PDATA_W'(cfg_q.split_mode);
			default:                     prdata = '0;
		endcase
	end

	// Sequencer owns both memories: the count histogram and the running
	// weight sums used by the selection search.
	fes_seq #(.MAX_LENGTH(MAX_LENGTH)) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.rand_select (rand_select),
		.rand_split  (rand_split),
		.cfg         (cfg_q),
		.res_ready   (res_ready),
		.res_write   (res_write),
		.res         (res)
	);

	// Output register: holds a finished item while the far side stalls, so
	// the sequencer can already take the next item.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_write) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_write) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign cut_length   = res_q.cut_length;
	assign piece_length = res_q.piece_length;
	assign total_weight = res_q.total_weight;
	assign finished     = res_q.finished;

endmodule
